// ===== hdl/nbbl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nbbl_pkg;

   localparam int MAX_BLOCKS_DEF = 16;
   localparam int MAX_BAYS_DEF   = 64;

   // bay estimate walks quarter boundaries 0..2
   localparam logic [1:0] EST_LAST_STEP = 2'd2;

   typedef enum logic [1:0] {
      KIND_BLOCK = 2'd0,
      KIND_BAY   = 2'd1,
      KIND_QUERY = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_LOADED     = 3'd0,
      ST_FULL       = 3'd1,
      ST_BAD_PARENT = 3'd2,
      ST_FOUND      = 3'd3,
      ST_NO_MATCH   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_BLK_ISSUE,
      OP_BAY_START,
      OP_BAY_ISSUE,
      OP_EST_READ,
      OP_EST_LOAD,
      OP_EST_VEC,
      OP_EST_MUL,
      OP_EST_CMP,
      OP_PUBLISH
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BLK_SCAN,
      S_BLK_DRAIN,
      S_BAY_SCAN,
      S_BAY_DRAIN,
      S_EST_READ,
      S_EST_LOAD,
      S_EST_VEC,
      S_EST_MUL,
      S_EST_CMP,
      S_RESULT
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic blk_empty;
      logic blk_end;
      logic bay_end;
      logic pipe_busy;
      logic bay_found;
      logic est_done;
   } stat_type;

endpackage

`default_nettype wire

// ===== hdl/nbbl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nbbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/nbbl_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nbbl_datapath #(
   parameter int MAX_BLOCKS = nbbl_pkg::MAX_BLOCKS_DEF,
   parameter int MAX_BAYS   = nbbl_pkg::MAX_BAYS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire nbbl_pkg::cmd_type   cmd,
   output nbbl_pkg::stat_type       stat,
   input  wire logic [1:0]          req_kind,
   input  wire logic [3:0]          req_parent_block,
   input  wire logic [7:0]          req_bay_number,
   input  wire logic signed [31:0]  req_center_lo,
   input  wire logic signed [30:0]  req_center_la,
   input  wire logic signed [31:0]  req_left_lo,
   input  wire logic signed [30:0]  req_left_la,
   input  wire logic signed [31:0]  req_right_lo,
   input  wire logic signed [30:0]  req_right_la,
   input  wire logic signed [31:0]  req_point_lo,
   input  wire logic signed [30:0]  req_point_la,
   output logic [2:0]               rsp_status,
   output logic [3:0]               rsp_block_slot,
   output logic [5:0]               rsp_bay_slot,
   output logic [7:0]               rsp_bay_estimate
);

   import nbbl_pkg::*;

   localparam int BIW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int YIW  = (MAX_BAYS > 1) ? $clog2(MAX_BAYS) : 1;
   localparam int BCW  = $clog2(MAX_BLOCKS + 1);
   localparam int YCW  = $clog2(MAX_BAYS + 1);
   localparam int CW   = (BCW > YCW) ? BCW : YCW;
   localparam int IW   = (BIW > YIW) ? BIW : YIW;
   localparam int PW   = (BCW > 4) ? BCW : 4;
   localparam int BXW  = (BIW > 4) ? BIW : 4;
   localparam int YXW  = (YIW > 6) ? YIW : 6;
   localparam int CMPW = (YCW > 9) ? YCW : 9;

   // bay entry layout
   localparam int BLK_W  = 63;
   localparam int BAY_W  = 201;
   localparam int C_LO   = 0;
   localparam int C_LA   = 32;
   localparam int L_LO   = 63;
   localparam int L_LA   = 95;
   localparam int R_LO   = 126;
   localparam int R_LA   = 158;
   localparam int ID_LSB = 189;
   localparam int PA_LSB = 197;

   // tables and counts
   logic [BCW-1:0]   block_count_ff, block_count_in;
   logic [YCW-1:0]   bay_count_ff, bay_count_in;
   logic             blk_we, bay_we;
   logic [BLK_W-1:0] blk_wdata, blk_rd;
   logic [BAY_W-1:0] bay_wdata, bay_rd;
   logic [YIW-1:0]   bay_raddr;

   // query point
   logic signed [31:0] pt_lo_ff;
   logic signed [30:0] pt_la_ff;

   // scan pipeline
   logic [CW-1:0]  scan_cnt_ff;
   logic           issue;
   logic           a_vld_ff, a_bay_ff, b_vld_ff, b_bay_ff, c_vld_ff, c_bay_ff;
   logic [IW-1:0]  a_idx_ff, b_idx_ff, c_idx_ff;
   logic signed [31:0] a_lo;
   logic signed [30:0] a_la;
   logic           a_match;
   logic signed [32:0] b_dlo_ff, b_dla_ff;
   logic signed [65:0] c_sqlo_ff, c_sqla_ff;
   logic [66:0]    d_sum;
   logic           d_better;
   logic [66:0]    best_dist_ff;
   logic           have_ff;
   logic [BIW-1:0] best_block_ff;
   logic [YIW-1:0] best_bay_ff;
   logic [YCW-1:0] in_block_ff;

   // bay estimate
   logic signed [32:0] e_dx_ff, e_dy_ff, e_dlx_ff, e_dly_ff;
   logic signed [37:0] e_vx_ff, e_vy_ff, e_dx38, e_dy38, e_mdx, e_mdy;
   logic signed [70:0] e_px_ff, e_py_ff;
   logic signed [71:0] e_dot;
   logic [7:0]     e_id_ff;
   logic [1:0]     k_ff;
   logic           e_hit;
   logic [7:0]     e_value;

   // result and output registers
   logic [2:0]     res_status_ff;
   logic [3:0]     res_block_ff;
   logic [5:0]     res_bay_ff;
   logic [7:0]     res_est_ff;
   logic [2:0]     rsp_status_ff;
   logic [3:0]     rsp_block_ff;
   logic [5:0]     rsp_bay_ff;
   logic [7:0]     rsp_est_ff;
   logic [BXW-1:0] blk_slot_x;
   logic [YXW-1:0] bay_slot_x;

   // table memories
   assign blk_wdata = {req_center_la, req_center_lo};
   assign bay_wdata = {req_parent_block, req_bay_number, req_right_la, req_right_lo,
                       req_left_la, req_left_lo, req_center_la, req_center_lo};
   assign bay_raddr = (cmd.op == OP_EST_READ) ? best_bay_ff : scan_cnt_ff[YIW-1:0];

   nbbl_ram #(.WIDTH(BLK_W), .DEPTH(MAX_BLOCKS)) u_blk_ram (
      .clock   (clock),
      .wr_en   (blk_we),
      .wr_addr (block_count_ff[BIW-1:0]),
      .wr_data (blk_wdata),
      .rd_addr (scan_cnt_ff[BIW-1:0]),
      .rd_data (blk_rd)
   );

   nbbl_ram #(.WIDTH(BAY_W), .DEPTH(MAX_BAYS)) u_bay_ram (
      .clock   (clock),
      .wr_en   (bay_we),
      .wr_addr (bay_count_ff[YIW-1:0]),
      .wr_data (bay_wdata),
      .rd_addr (bay_raddr),
      .rd_data (bay_rd)
   );

   // load decisions
   always_comb begin
      blk_we         = 1'b0;
      bay_we         = 1'b0;
      block_count_in = block_count_ff;
      bay_count_in   = bay_count_ff;
      if (cmd.op == OP_ACCEPT) begin
         if (req_kind == KIND_BLOCK && 32'(block_count_ff) < MAX_BLOCKS) begin
            blk_we         = 1'b1;
            block_count_in = block_count_ff + BCW'(1);
         end
         if (req_kind == KIND_BAY && PW'(req_parent_block) < PW'(block_count_ff)
             && 32'(bay_count_ff) < MAX_BAYS) begin
            bay_we       = 1'b1;
            bay_count_in = bay_count_ff + YCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= '0;
         bay_count_ff   <= '0;
      end else begin
         block_count_ff <= block_count_in;
         bay_count_ff   <= bay_count_in;
      end
   end

   // scan issue
   assign stat.blk_end = (scan_cnt_ff == CW'(block_count_ff));
   assign stat.bay_end = (scan_cnt_ff == CW'(bay_count_ff));
   assign issue = (cmd.op == OP_BLK_ISSUE && !stat.blk_end) ||
                  (cmd.op == OP_BAY_ISSUE && !stat.bay_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         a_vld_ff    <= 1'b0;
         b_vld_ff    <= 1'b0;
         c_vld_ff    <= 1'b0;
         have_ff     <= 1'b0;
      end else begin
         if (cmd.op == OP_ACCEPT || cmd.op == OP_BAY_START) begin
            scan_cnt_ff <= '0;
         end else if (issue) begin
            scan_cnt_ff <= scan_cnt_ff + CW'(1);
         end
         a_vld_ff <= issue;
         b_vld_ff <= a_vld_ff && (!a_bay_ff || a_match);
         c_vld_ff <= b_vld_ff;
         if (cmd.op == OP_ACCEPT || cmd.op == OP_BAY_START) begin
            have_ff <= 1'b0;
         end else if (c_vld_ff && d_better) begin
            have_ff <= 1'b1;
         end
      end
   end

   // stage a: entry read, stage b: differences
   assign a_lo    = a_bay_ff ? bay_rd[C_LO +: 32] : blk_rd[C_LO +: 32];
   assign a_la    = a_bay_ff ? bay_rd[C_LA +: 31] : blk_rd[C_LA +: 31];
   assign a_match = (BXW'(bay_rd[PA_LSB +: 4]) == BXW'(best_block_ff));

   always_ff @(posedge clock) begin
      a_bay_ff <= (cmd.op == OP_BAY_ISSUE);
      a_idx_ff <= IW'(scan_cnt_ff);
      b_bay_ff <= a_bay_ff;
      b_idx_ff <= a_idx_ff;
      b_dlo_ff <= 33'(a_lo) - 33'(pt_lo_ff);
      b_dla_ff <= 33'(a_la) - 33'(pt_la_ff);
      c_bay_ff <= b_bay_ff;
      c_idx_ff <= b_idx_ff;
      c_sqlo_ff <= b_dlo_ff * b_dlo_ff;
      c_sqla_ff <= b_dla_ff * b_dla_ff;
   end

   // stage d: sum and keep the nearest
   assign d_sum    = {1'b0, c_sqlo_ff} + {1'b0, c_sqla_ff};
   assign d_better = !have_ff || (d_sum < best_dist_ff);

   always_ff @(posedge clock) begin
      if (c_vld_ff && d_better) begin
         best_dist_ff <= d_sum;
         if (c_bay_ff) begin
            best_bay_ff <= c_idx_ff[YIW-1:0];
         end else begin
            best_block_ff <= c_idx_ff[BIW-1:0];
         end
      end
      if (cmd.op == OP_BAY_START) begin
         in_block_ff <= '0;
      end else if (a_vld_ff && a_bay_ff && a_match) begin
         in_block_ff <= in_block_ff + YCW'(1);
      end
      if (cmd.op == OP_ACCEPT) begin
         pt_lo_ff <= req_point_lo;
         pt_la_ff <= req_point_la;
      end
   end

   assign stat.pipe_busy = a_vld_ff || b_vld_ff || c_vld_ff;
   assign stat.bay_found = have_ff;
   assign stat.blk_empty = (block_count_ff == '0);

   // quarter estimate along the top edge
   assign e_dx38 = 38'(e_dx_ff);
   assign e_dy38 = 38'(e_dy_ff);
   always_comb begin
      unique case (k_ff)
         2'd1: begin
            e_mdx = e_dx38 + (e_dx38 <<< 1);
            e_mdy = e_dy38 + (e_dy38 <<< 1);
         end
         2'd2: begin
            e_mdx = e_dx38 + (e_dx38 <<< 2);
            e_mdy = e_dy38 + (e_dy38 <<< 2);
         end
         default: begin
            e_mdx = e_dx38;
            e_mdy = e_dy38;
         end
      endcase
   end

   assign e_dot = 72'(e_px_ff) + 72'(e_py_ff);
   assign e_hit = (e_dot > 0);
   assign stat.est_done = e_hit || (k_ff == EST_LAST_STEP);

   always_comb begin
      if (e_hit) begin
         if (k_ff == 2'd0) begin
            e_value = (e_id_ff != 8'd0) ? e_id_ff - 8'd1 : 8'd0;
         end else begin
            e_value = e_id_ff;
         end
      end else if (CMPW'(e_id_ff) + CMPW'(1) < CMPW'(in_block_ff) && e_id_ff != 8'hFF) begin
         e_value = e_id_ff + 8'd1;
      end else begin
         e_value = e_id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EST_LOAD) begin
         e_dx_ff  <= 33'($signed(bay_rd[R_LO +: 32])) - 33'($signed(bay_rd[L_LO +: 32]));
         e_dy_ff  <= 33'($signed(bay_rd[R_LA +: 31])) - 33'($signed(bay_rd[L_LA +: 31]));
         e_dlx_ff <= 33'($signed(bay_rd[L_LO +: 32])) - 33'(pt_lo_ff);
         e_dly_ff <= 33'($signed(bay_rd[L_LA +: 31])) - 33'(pt_la_ff);
         e_id_ff  <= bay_rd[ID_LSB +: 8];
         k_ff     <= 2'd0;
      end
      if (cmd.op == OP_EST_VEC) begin
         e_vx_ff <= (38'(e_dlx_ff) <<< 3) + e_mdx;
         e_vy_ff <= (38'(e_dly_ff) <<< 3) + e_mdy;
      end
      if (cmd.op == OP_EST_MUL) begin
         e_px_ff <= e_dx_ff * e_vx_ff;
         e_py_ff <= e_dy_ff * e_vy_ff;
      end
      if (cmd.op == OP_EST_CMP && !stat.est_done) begin
         k_ff <= k_ff + 2'd1;
      end
   end

   // result registers
   assign blk_slot_x = BXW'(best_block_ff);
   assign bay_slot_x = YXW'(best_bay_ff);

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_ACCEPT: begin
            res_block_ff <= '0;
            res_bay_ff   <= '0;
            res_est_ff   <= '0;
            if (req_kind == KIND_BLOCK) begin
               res_status_ff <= blk_we ? ST_LOADED : ST_FULL;
            end else if (req_kind == KIND_BAY) begin
               if (PW'(req_parent_block) >= PW'(block_count_ff)) begin
                  res_status_ff <= ST_BAD_PARENT;
               end else begin
                  res_status_ff <= bay_we ? ST_LOADED : ST_FULL;
               end
            end else begin
               res_status_ff <= ST_NO_MATCH;
            end
         end
         OP_EST_READ: begin
            res_status_ff <= ST_FOUND;
            res_block_ff  <= blk_slot_x[3:0];
            res_bay_ff    <= bay_slot_x[5:0];
         end
         OP_EST_CMP: begin
            if (stat.est_done) begin
               res_est_ff <= e_value;
            end
         end
         OP_PUBLISH: begin
            rsp_status_ff <= res_status_ff;
            rsp_block_ff  <= res_block_ff;
            rsp_bay_ff    <= res_bay_ff;
            rsp_est_ff    <= res_est_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_block_slot   = rsp_block_ff;
   assign rsp_bay_slot     = rsp_bay_ff;
   assign rsp_bay_estimate = rsp_est_ff;

   // checks
   a_block_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(block_count_ff) <= MAX_BLOCKS)
      else $error("block count beyond table");

   a_bay_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(bay_count_ff) <= MAX_BAYS)
      else $error("bay count beyond table");

   a_est_needs_bay: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EST_READ) |-> (have_ff && !stat.pipe_busy))
      else $error("estimate started without a settled nearest bay");

   a_scan_quiet_on_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_ACCEPT) |-> !stat.pipe_busy)
      else $error("item accepted while scan pipeline busy");

endmodule

`default_nettype wire

// ===== hdl/nbbl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nbbl_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_kind,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire nbbl_pkg::stat_type stat,
   output nbbl_pkg::cmd_type       cmd
);

   import nbbl_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_ACCEPT;
               if (req_kind == KIND_QUERY && !stat.blk_empty) begin
                  state_in = S_BLK_SCAN;
               end else begin
                  state_in = S_RESULT;
               end
            end
         end
         S_BLK_SCAN: begin
            cmd.op = OP_BLK_ISSUE;
            if (stat.blk_end) begin
               state_in = S_BLK_DRAIN;
            end
         end
         S_BLK_DRAIN: begin
            if (!stat.pipe_busy) begin
               cmd.op   = OP_BAY_START;
               state_in = S_BAY_SCAN;
            end
         end
         S_BAY_SCAN: begin
            cmd.op = OP_BAY_ISSUE;
            if (stat.bay_end) begin
               state_in = S_BAY_DRAIN;
            end
         end
         S_BAY_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = stat.bay_found ? S_EST_READ : S_RESULT;
            end
         end
         S_EST_READ: begin
            cmd.op   = OP_EST_READ;
            state_in = S_EST_LOAD;
         end
         S_EST_LOAD: begin
            cmd.op   = OP_EST_LOAD;
            state_in = S_EST_VEC;
         end
         S_EST_VEC: begin
            cmd.op   = OP_EST_VEC;
            state_in = S_EST_MUL;
         end
         S_EST_MUL: begin
            cmd.op   = OP_EST_MUL;
            state_in = S_EST_CMP;
         end
         S_EST_CMP: begin
            cmd.op   = OP_EST_CMP;
            state_in = stat.est_done ? S_RESULT : S_EST_VEC;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hdl/nearest_block_bay_locator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Nearest block / bay locator. Block and bay entries are loaded in arrival order;
// a query returns the block whose centre is nearest the point, the nearest bay of
// that block, and a bay number estimated from the point's place along the bay's
// top edge. One item is handled at a time and each gives one result item. A query
// that finds a bay tries one to three quarter steps. Blocks and bays are streamed
// one entry per cycle through a four-stage squared-distance pipeline reading the
// single read port of each table memory. The next item is taken while an earlier
// result still waits on the result channel.
module nearest_block_bay_locator_top #(
   parameter int MAX_BLOCKS = nbbl_pkg::MAX_BLOCKS_DEF,
   parameter int MAX_BAYS   = nbbl_pkg::MAX_BAYS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_kind,
   input  wire logic [3:0]         req_parent_block,
   input  wire logic [7:0]         req_bay_number,
   input  wire logic signed [31:0] req_center_lo,
   input  wire logic signed [30:0] req_center_la,
   input  wire logic signed [31:0] req_left_lo,
   input  wire logic signed [30:0] req_left_la,
   input  wire logic signed [31:0] req_right_lo,
   input  wire logic signed [30:0] req_right_la,
   input  wire logic signed [31:0] req_point_lo,
   input  wire logic signed [30:0] req_point_la,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_status,
   output logic [3:0]              rsp_block_slot,
   output logic [5:0]              rsp_bay_slot,
   output logic [7:0]              rsp_bay_estimate
);

   import nbbl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   nbbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   nbbl_datapath #(.MAX_BLOCKS(MAX_BLOCKS), .MAX_BAYS(MAX_BAYS)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_parent_block (req_parent_block),
      .req_bay_number   (req_bay_number),
      .req_center_lo    (req_center_lo),
      .req_center_la    (req_center_la),
      .req_left_lo      (req_left_lo),
      .req_left_la      (req_left_la),
      .req_right_lo     (req_right_lo),
      .req_right_la     (req_right_la),
      .req_point_lo     (req_point_lo),
      .req_point_la     (req_point_la),
      .rsp_status       (rsp_status),
      .rsp_block_slot   (rsp_block_slot),
      .rsp_bay_slot     (rsp_bay_slot),
      .rsp_bay_estimate (rsp_bay_estimate)
   );

endmodule

`default_nettype wire
